@@ hw/rtl/gfb_pkg.sv @@
// Goertzel filter bank package: widths, opcodes, coefficient reset values.
// Shared by gfb_mac, gfb_mag and goertzel_filter_bank_unit.
`timescale 1ns / 1ps
package gfb_pkg;

  localparam int BIN_COUNT = 5;                    // active bins, 1..5
  localparam int BIN_W     = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int CFG_COUNT = 5;                    // coefficient registers
  localparam int CFG_W     = 3;                    // cfg_index width
  localparam int IDX_W     = 3;                    // bin_index field width
  localparam int COEF_W    = 16;
  localparam int SMP_W     = 16;
  localparam int ACC_W     = 32;
  localparam int PROD_W    = COEF_W + ACC_W;
  localparam int FRAC      = 14;
  localparam int MAG_W     = 16;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  localparam coef_t COEF_RESET [CFG_COUNT] = '{
    16'sd31539, 16'sd25093, 16'sd7852, -16'sd16854, -16'sd30274
  };

endpackage

@@ hw/rtl/gfb_mac.sv @@
// Shared resonator arithmetic: registered 16x32 product, then
// sample + (product >>> FRAC) - delay_two, wrapped to 32 bits. Uses gfb_pkg.
`timescale 1ns / 1ps
module gfb_mac (
  input  logic          clk,
  input  logic          mul_en,
  input  gfb_pkg::coef_t coef,
  input  gfb_pkg::acc_t  d1,
  input  gfb_pkg::acc_t  d2,
  input  logic signed [gfb_pkg::SMP_W-1:0] sample,
  output gfb_pkg::acc_t  sum
);
  import gfb_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  acc_t                     q_lo;

  assign prod_nxt = PROD_W'(coef) * PROD_W'(d1);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // low word of the floor shift is all the wrapped sum needs
  assign q_lo = prod_r[FRAC +: ACC_W];
  assign sum  = ACC_W'(sample) + q_lo - d2;

endmodule

@@ hw/rtl/gfb_mag.sv @@
// Alpha-max-plus-beta-min magnitude: absolute values registered, then
// max + min/2 saturated to 16 bits. Uses gfb_pkg.
`timescale 1ns / 1ps
module gfb_mag (
  input  logic                       clk,
  input  logic                       load,
  input  gfb_pkg::acc_t              d1,
  input  gfb_pkg::acc_t              d2,
  output logic [gfb_pkg::MAG_W-1:0]  mag
);
  import gfb_pkg::*;

  logic [ACC_W-1:0] a_r, b_r;
  logic [ACC_W-1:0] a_nxt, b_nxt;
  logic [ACC_W-1:0] mx, mn;
  logic [ACC_W:0]   total;

  // most negative value wraps to 2^31, exact as unsigned
  assign a_nxt = d1[ACC_W-1] ? (~d1 + 1'b1) : d1;
  assign b_nxt = d2[ACC_W-1] ? (~d2 + 1'b1) : d2;

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  always_comb begin
    mx    = (a_r > b_r) ? a_r : b_r;
    mn    = (a_r > b_r) ? b_r : a_r;
    total = {1'b0, mx} + {2'b00, mn[ACC_W-1:1]};
    mag   = (total[ACC_W:MAG_W] != '0) ? {MAG_W{1'b1}} : total[MAG_W-1:0];
  end

endmodule

@@ hw/rtl/goertzel_filter_bank_unit.sv @@
// Goertzel filter bank top: sequencer, coefficient and delay registers,
// output register. Uses gfb_pkg, gfb_mac, gfb_mag.
//
//  channel | ports                 | payload
//  in      | in_tvalid/in_tready   | tuser: op[1:0]; tdata: sample[15:0]
//  out     | out_tvalid/out_tready | tuser: bin_index[2:0]; tdata: magnitude; tlast
//  cfg     | cfg_valid/cfg_ready   | cfg_index: register; cfg_data: coefficient
//
// Clear and unused ops finish in the accept cycle. After the accept, a sample steps
// each bin in turn through ST_MUL then ST_ACC, sharing the one multiplier.
// A read steps each bin through ST_ABS, ST_LOAD and ST_OUT; each beat waits for out_tready.
// in_tready is low while a sample or read is in flight; cfg is always ready.
// rst_n (sync) zeroes all delays and loads the default coefficients.
`timescale 1ns / 1ps
module goertzel_filter_bank_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [1:0]                   in_tuser,   // op[1:0]
  input  logic [15:0]                  in_tdata,   // sample[15:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [gfb_pkg::IDX_W-1:0]    out_tuser,  // bin_index[2:0]
  output logic [gfb_pkg::MAG_W-1:0]    out_tdata,  // magnitude[15:0]
  output logic                         out_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gfb_pkg::CFG_W-1:0]    cfg_index,
  input  logic [gfb_pkg::COEF_W-1:0]   cfg_data
);
  import gfb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_ABS  = 6'b001000,
    ST_LOAD = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic signed [SMP_W-1:0] sample_r;
  coef_t            coef_r [CFG_COUNT];
  acc_t             d1_r [BIN_COUNT];
  acc_t             d2_r [BIN_COUNT];
  acc_t             d1_sel, d2_sel, sum;
  coef_t            coef_sel;
  logic             bin_last;
  logic [MAG_W-1:0] mag;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_bin_r;
  logic [MAG_W-1:0] out_mag_r;
  logic             out_last_r;
  logic             in_fire, out_fire;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign bin_last  = (bin_r == BIN_W'(BIN_COUNT - 1));

  assign d1_sel   = d1_r[bin_r];
  assign d2_sel   = d2_r[bin_r];
  assign coef_sel = coef_r[CFG_W'(bin_r)];

  gfb_mac u_mac (
    .clk    (clk),
    .mul_en (state_r == ST_MUL),
    .coef   (coef_sel),
    .d1     (d1_sel),
    .d2     (d2_sel),
    .sample (sample_r),
    .sum    (sum)
  );

  gfb_mag u_mag (
    .clk  (clk),
    .load (state_r == ST_ABS),
    .d1   (d1_sel),
    .d2   (d2_sel),
    .mag  (mag)
  );

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    case (state_r)
      ST_IDLE: begin
        bin_nxt = '0;
        if (in_fire) begin
          case (in_tuser)
            OP_SAMPLE: state_nxt = ST_MUL;
            OP_READ:   state_nxt = ST_ABS;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (bin_last) begin
          state_nxt = ST_IDLE;
        end else begin
          bin_nxt   = bin_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_ABS:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_fire) begin
          if (bin_last) begin
            state_nxt = ST_IDLE;
          end else begin
            bin_nxt   = bin_r + 1'b1;
            state_nxt = ST_ABS;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CFG_COUNT; i++) begin
        coef_r[i] <= COEF_RESET[i];
      end
      for (int i = 0; i < BIN_COUNT; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      bin_r   <= bin_nxt;
      if (cfg_valid && (cfg_index < CFG_W'(CFG_COUNT))) begin
        coef_r[cfg_index] <= cfg_data;
      end
      if (in_fire && (in_tuser == OP_CLEAR)) begin
        for (int i = 0; i < BIN_COUNT; i++) begin
          d1_r[i] <= '0;
          d2_r[i] <= '0;
        end
      end
      if (state_r == ST_ACC) begin
        d2_r[bin_r] <= d1_sel;
        d1_r[bin_r] <= sum;
      end
      if (state_r == ST_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_tdata;
    end
    if (state_r == ST_LOAD) begin
      out_bin_r  <= IDX_W'(bin_r);
      out_mag_r  <= mag;
      out_last_r <= bin_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_bin_r;
  assign out_tdata  = out_mag_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("result pending while accepting input");

  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == IDX_W'(BIN_COUNT - 1)))
    else $error("tlast on a bin other than the final one");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready after final read beat");

  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> !out_tvalid ##2 out_tvalid)
    else $error("read beats out of sequence");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for goertzel_filter_bank_unit: directed table, then random frames
// per coefficient setting, with results checked against an in-bench resonator predictor.
// Depends on gfb_pkg and goertzel_filter_bank_unit.
`timescale 1ns / 1ps
module testbench;
  import gfb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PREDICT = -1;          // row magnitude comes from the predictor
  localparam int DIRECTED_ROWS = 23;
  localparam int PHASE_ITEMS = 44;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 30;

  localparam int BANK_MAX = 0;
  localparam int BANK_MIN = 1;
  localparam int BANK_ZERO = 2;
  localparam int BANK_RANDOM = 3;
  localparam int BANK_EXTREME = 4;

  typedef struct packed {
    logic [IDX_W-1:0] bin;
    logic [MAG_W-1:0] mag;
    logic             last;
  } bin_result_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] smp;
    int          mag;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = 2'd0;
  logic [15:0] in_tdata = 16'd0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [IDX_W-1:0] out_tuser;
  logic [MAG_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // predictor state
  coef_t bank_coef [CFG_COUNT];
  acc_t  res_prev1 [BIN_COUNT];
  acc_t  res_prev2 [BIN_COUNT];
  bin_result_t mag_pending [$];

  int  err_count = 0;
  int  stall_cycles = 0;
  bit  no_idle = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_READ,   16'h0000, 0},          // fresh from reset
    '{OP_SAMPLE, 16'h7fff, PREDICT},
    '{OP_READ,   16'h0000, 32767},
    '{OP_SAMPLE, 16'h8000, PREDICT},
    '{OP_READ,   16'h0000, PREDICT},
    '{OP_UNUSED, 16'h5555, PREDICT},
    '{OP_READ,   16'h0000, PREDICT},
    '{OP_CLEAR,  16'hffff, PREDICT},
    '{OP_READ,   16'h0000, 0},
    '{OP_SAMPLE, 16'h8000, PREDICT},
    '{OP_READ,   16'h0000, 32768},
    '{OP_SAMPLE, 16'h0001, PREDICT},
    '{OP_SAMPLE, 16'hffff, PREDICT},
    '{OP_SAMPLE, 16'h0000, PREDICT},
    '{OP_READ,   16'h0000, PREDICT},
    '{OP_UNUSED, 16'haaaa, PREDICT},
    '{OP_CLEAR,  16'h0000, PREDICT},
    '{OP_SAMPLE, 16'h7fff, PREDICT},
    '{OP_SAMPLE, 16'h7fff, PREDICT},
    '{OP_SAMPLE, 16'h7fff, PREDICT},
    '{OP_READ,   16'h0000, PREDICT},
    '{OP_CLEAR,  16'h0000, PREDICT},
    '{OP_READ,   16'h0000, 0}
  };

  goertzel_filter_bank_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 32);
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Clear every resonator, advance each by one sample, or queue the expected bank magnitudes.
  task automatic goertzel_apply(input logic [1:0] op, input logic [15:0] smp, input int typed);
    logic signed [15:0] s;
    logic signed [47:0] prod;
    logic signed [47:0] wide;
    logic [31:0] a, d, mx, mn, mag;
    bin_result_t r;
    s = smp;
    case (op)
      OP_CLEAR: begin
        for (int b = 0; b < BIN_COUNT; b++) begin
          res_prev1[b] = '0;
          res_prev2[b] = '0;
        end
      end
      OP_SAMPLE: begin
        for (int b = 0; b < BIN_COUNT; b++) begin
          prod = bank_coef[b] * res_prev1[b];
          wide = s + (prod >>> FRAC) - res_prev2[b];
          res_prev2[b] = res_prev1[b];
          res_prev1[b] = wide[ACC_W-1:0];
        end
      end
      OP_READ: begin
        for (int b = 0; b < BIN_COUNT; b++) begin
          // -2^31 maps to 2^31, still exact in 32 unsigned bits
          a = res_prev1[b][ACC_W-1] ? -res_prev1[b] : res_prev1[b];
          d = res_prev2[b][ACC_W-1] ? -res_prev2[b] : res_prev2[b];
          mx = (a > d) ? a : d;
          mn = (a > d) ? d : a;
          mag = mx + (mn >> 1);
          if (mag > 32'd65535) mag = 32'd65535;
          r.bin = IDX_W'(b);
          r.mag = (typed == PREDICT) ? mag[MAG_W-1:0] : typed[MAG_W-1:0];
          r.last = (b == BIN_COUNT - 1);
          mag_pending.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] op, input logic [15:0] smp, input int typed);
    while (!no_idle && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    goertzel_apply(op, smp, typed);
  endtask

  task automatic write_coef(input logic [CFG_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < CFG_COUNT) bank_coef[idx] = val;
  endtask

  // Drain results, then allow for a sample still in the resonator pipeline.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mag_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bank(input int mode);
    logic [COEF_W-1:0] val;
    for (int i = 0; i < CFG_COUNT; i++) begin
      case (mode)
        BANK_MAX:    val = 16'h7fff;
        BANK_MIN:    val = 16'h8000;
        BANK_ZERO:   val = 16'h0000;
        BANK_RANDOM: val = COEF_W'($urandom_range(65535));
        default: begin
          case ($urandom_range(3))
            0: val = 16'h7fff;
            1: val = 16'h8000;
            2: val = 16'h0000;
            default: val = COEF_W'($urandom_range(65535));
          endcase
        end
      endcase
      write_coef(CFG_W'(i), val);
    end
    // out-of-range index must not disturb the bank
    write_coef(CFG_W'($urandom_range(7, CFG_COUNT)), COEF_W'($urandom_range(65535)));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    if ($urandom_range(99) < 70) return 16'($signed($urandom_range(3000)) - 1500);
    return 16'($urandom_range(65535));
  endfunction

  // Frames of clear, a few samples, read; with stray ops mixed in.
  task automatic random_phase(input int items);
    int sent;
    int frame_len;
    sent = 0;
    while (sent < items) begin
      send_item(OP_CLEAR, 16'($urandom_range(65535)), PREDICT);
      sent++;
      frame_len = $urandom_range(8, 1);
      for (int k = 0; k < frame_len; k++) begin
        case ($urandom_range(19))
          0, 1: send_item(OP_UNUSED, 16'($urandom_range(65535)), PREDICT);
          2:    send_item(OP_READ, 16'($urandom_range(65535)), PREDICT);
          3:    send_item(OP_CLEAR, 16'($urandom_range(65535)), PREDICT);
          default: send_item(OP_SAMPLE, pick_sample(), PREDICT);
        endcase
        sent++;
      end
      send_item(OP_READ, 16'($urandom_range(65535)), PREDICT);
      sent++;
    end
  endtask

  always @(posedge clk) begin : result_check
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (mag_pending.size() == 0) begin
        note_error($sformatf("unexpected result bin=%0d mag=%0d last=%0b",
                             out_tuser, out_tdata, out_tlast));
      end else begin
        want = mag_pending.pop_front();
        if (out_tuser !== want.bin || out_tdata !== want.mag || out_tlast !== want.last)
          note_error($sformatf("bin exp %0d got %0d, mag exp %0d got %0d, last exp %0b got %0b",
                               want.bin, out_tuser, want.mag, out_tdata, want.last, out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < CFG_COUNT; i++) bank_coef[i] = COEF_RESET[i];
    for (int b = 0; b < BIN_COUNT; b++) begin
      res_prev1[b] = '0;
      res_prev2[b] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(directed_rows[i].op, directed_rows[i].smp, directed_rows[i].mag);

    wait_idle();
    set_bank(BANK_MAX);
    random_phase(PHASE_ITEMS);

    wait_idle();
    set_bank(BANK_MIN);
    no_idle = 1'b1;
    random_phase(PHASE_ITEMS);
    no_idle = 1'b0;

    wait_idle();
    set_bank(BANK_ZERO);
    random_phase(PHASE_ITEMS);

    wait_idle();
    set_bank(BANK_RANDOM);
    random_phase(PHASE_ITEMS);

    wait_idle();
    set_bank(BANK_EXTREME);
    random_phase(PHASE_ITEMS);

    wait_idle();
    if (mag_pending.size() != 0)
      note_error($sformatf("%0d results never arrived", mag_pending.size()));
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
